// ===== src/lppd_pkg.sv =====
// Shared constants for the length-prefixed packet deframer.
package lppd_pkg;

    localparam logic [7:0]  DEFAULT_VERSION    = 8'd1;
    localparam logic [31:0] DEFAULT_MAX_LENGTH = 32'd100000;

    // configuration register indexes
    localparam logic [0:0] REG_EXPECTED_VERSION = 1'd0;
    localparam logic [0:0] REG_MAX_LENGTH       = 1'd1;

    // result status codes
    localparam logic [1:0] ST_PAYLOAD     = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_BAD_VERSION = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE   = 2'd3;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [1:0] status;
        logic       last_of_packet;
    } result_t;

endpackage

// ===== src/length_prefixed_packet_deframer.sv =====
// Length-prefixed packet deframer: takes one stream byte per transfer, parses a six-byte
// header (version, 32-bit little-endian length, type) and passes the payload bytes through
// tagged with the packet type. One byte is taken every clock cycle unless the skid
// register is full; each byte is parsed in the cycle it is taken and its result, if any,
// is registered. A two-entry output stage (result register plus skid register) lets
// one more result-producing byte in while the result side stalls; bytes that give no
// result keep flowing until the skid register fills. Header bytes give no result
// except a bad version byte (status 2), a length above max_length (status 3, no payload
// consumed) and a zero length (status 1). Configuration is written through the cfg port,
// which is always ready; its one-bit index selects one of the two registers.
module length_prefixed_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  payload_byte,
    output logic [7:0]  packet_type,
    output logic [1:0]  status,
    output logic        last_of_packet
);

    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_LEN0    = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LEN2    = 3'd3,
        PH_LEN3    = 3'd4,
        PH_TYPE    = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             exp_version_reg;
    logic [31:0]            max_length_reg;
    logic [31:0]            length_reg, length_next;
    logic [7:0]             type_reg, type_next;
    logic [31:0]            remaining_reg, remaining_next;
    lppd_pkg::result_t      out_reg, skid_reg, res;
    logic                   out_valid_reg, skid_valid_reg;
    logic                   res_valid;
    logic                   in_fire, out_fire;

    assign cfg_ready  = 1'b1;
    assign data_ready = !skid_valid_reg;
    assign in_fire    = data_valid && data_ready;
    assign out_fire   = out_valid_reg && result_ready;

    assign result_valid   = out_valid_reg;
    assign payload_byte   = out_reg.payload_byte;
    assign packet_type    = out_reg.packet_type;
    assign status         = out_reg.status;
    assign last_of_packet = out_reg.last_of_packet;

    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        type_next      = type_reg;
        remaining_next = remaining_reg;
        res_valid      = 1'b0;
        res            = '0;
        case (phase_reg)
            PH_PAYLOAD:
            begin
                remaining_next     = remaining_reg - 32'd1;
                res_valid          = 1'b1;
                res.payload_byte   = data_byte;
                res.packet_type    = type_reg;
                res.status         = lppd_pkg::ST_PAYLOAD;
                res.last_of_packet = (remaining_reg == 32'd1);
                if (remaining_reg == 32'd1)
                begin
                    phase_next = PH_VERSION;
                end
            end
            PH_LEN0:
            begin
                length_next = {24'd0, data_byte};
                phase_next  = PH_LEN1;
            end
            PH_LEN1:
            begin
                length_next[15:8] = data_byte;
                phase_next        = PH_LEN2;
            end
            PH_LEN2:
            begin
                length_next[23:16] = data_byte;
                phase_next         = PH_LEN3;
            end
            PH_LEN3:
            begin
                length_next[31:24] = data_byte;
                phase_next         = PH_TYPE;
            end
            PH_TYPE:
            begin
                type_next       = data_byte;
                phase_next      = PH_VERSION;
                res.packet_type = data_byte;
                if (length_reg > max_length_reg)
                begin
                    res_valid          = 1'b1;
                    res.status         = lppd_pkg::ST_TOO_LARGE;
                    res.last_of_packet = 1'b1;
                end
                else if (length_reg == 32'd0)
                begin
                    res_valid          = 1'b1;
                    res.status         = lppd_pkg::ST_EMPTY;
                    res.last_of_packet = 1'b1;
                end
                else
                begin
                    remaining_next = length_reg;
                    phase_next     = PH_PAYLOAD;
                end
            end
            default:
            begin
                if (data_byte != exp_version_reg)
                begin
                    phase_next = PH_VERSION;
                    res_valid  = 1'b1;
                    res.status = lppd_pkg::ST_BAD_VERSION;
                end
                else
                begin
                    phase_next = PH_LEN0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= lppd_pkg::DEFAULT_VERSION;
            max_length_reg  <= lppd_pkg::DEFAULT_MAX_LENGTH;
            phase_reg       <= PH_VERSION;
            length_reg      <= '0;
            type_reg        <= '0;
            remaining_reg   <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    lppd_pkg::REG_EXPECTED_VERSION: exp_version_reg <= cfg_data[7:0];
                    lppd_pkg::REG_MAX_LENGTH:       max_length_reg  <= cfg_data;
                    default:                        ;
                endcase
            end
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                length_reg    <= length_next;
                type_reg      <= type_next;
                remaining_reg <= remaining_next;
            end
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire && res_valid)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

endmodule

// ===== src/lppd_checker.sv =====
// Port-level checks for the length-prefixed packet deframer, bound to the top level.
module lppd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       data_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] payload_byte,
    input logic [7:0] packet_type,
    input logic [1:0] status,
    input logic       last_of_packet
);

    // input stalls only when the result side holds a pending result
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !data_ready |-> result_valid)
        else $error("input stalled with no result pending");

    a_bad_version_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == lppd_pkg::ST_BAD_VERSION) |->
        (payload_byte == 8'd0 && packet_type == 8'd0 && !last_of_packet))
        else $error("bad-version result carries nonzero fields");

    a_header_result_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == lppd_pkg::ST_EMPTY || status == lppd_pkg::ST_TOO_LARGE))
        |-> (last_of_packet && payload_byte == 8'd0))
        else $error("empty or oversize result not marked last");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
        (result_valid && $stable(payload_byte) && $stable(packet_type) && $stable(status)
         && $stable(last_of_packet)))
        else $error("stalled result changed");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .data_ready     (data_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .payload_byte   (payload_byte),
    .packet_type    (packet_type),
    .status         (status),
    .last_of_packet (last_of_packet)
);
